// ===== rtl/core/ppghr_pkg.sv =====
// shared constants, register codes and controller/datapath types for the heart rate block
package ppghr_pkg;

    // sample ring geometry
    localparam int WINDOW      = 5;
    localparam int SLOT_W      = $clog2(WINDOW);
    localparam int HALF_WINDOW = WINDOW / 2;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int STAMP_W  = 32;
    localparam int RATE_W   = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL   = 2'd2;

    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET    = 16'd20000;
    localparam logic [CFG_DATA_W-1:0] MIN_INTERVAL_RESET = 16'd333;
    localparam logic [CFG_DATA_W-1:0] MAX_INTERVAL_RESET = 16'd1500;

    // rate = 60000 / interval, one quotient bit per cycle
    localparam logic [RATE_W-1:0] RATE_NUMERATOR = 16'd60000;
    localparam int DIV_STEPS = RATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // request opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic clear;
        logic write_ring;
        logic eval;
        logic decide;
        logic div_step;
        logic div_last;
        logic load_out;
    } ppghr_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic op;
        logic need_div;
    } ppghr_status_t;

endpackage

// ===== rtl/core/ppghr_sample_if.sv =====
// sample request channel: valid/ready handshake with opcode, sample and timestamp
interface ppghr_sample_if;
    import ppghr_pkg::*;

    logic                op;
    logic [SAMPLE_W-1:0] ppg_sample;
    logic [STAMP_W-1:0]  timestamp;
    logic                valid;
    logic                ready;

    modport source (output op, output ppg_sample, output timestamp, output valid,
                    input ready);
    modport sink   (input op, input ppg_sample, input timestamp, input valid,
                    output ready);
endinterface

// ===== rtl/core/ppghr_rate_if.sv =====
// rate result channel: valid/ready handshake with heart rate payload
interface ppghr_rate_if;
    import ppghr_pkg::*;

    logic [RATE_W-1:0] heart_rate;
    logic              valid;
    logic              ready;

    modport source (output heart_rate, output valid, input ready);
    modport sink   (input heart_rate, input valid, output ready);
endinterface

// ===== rtl/core/ppghr_ctrl.sv =====
// controller FSM: sequences one sample request through write, evaluate, optional divide, output
module ppghr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    samples_valid,
    output logic                    samples_ready,
    output logic                    rates_valid,
    input  logic                    rates_ready,
    input  ppghr_pkg::ppghr_status_t status,
    output ppghr_pkg::ppghr_cmd_t    cmd
);
    import ppghr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WRITE  = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    assign samples_ready = (state_reg == S_IDLE);
    assign rates_valid   = out_valid_reg;
    assign out_free      = !out_valid_reg || rates_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && rates_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (samples_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (status.op == OP_CLEAR)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.write_ring = 1'b1;
                    state_next     = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                cnt_next   = '0;
                state_next = status.need_div ? S_DIV : S_FINISH;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    cmd.div_last = 1'b1;
                    state_next   = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/ppghr_datapath.sv =====
// datapath: sample ring, peak test, interval check, radix-2 rate divider and output register
module ppghr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ppghr_pkg::ppghr_cmd_t               cmd,
    output ppghr_pkg::ppghr_status_t            status,
    input  logic                                op,
    input  logic [ppghr_pkg::SAMPLE_W-1:0]      ppg_sample,
    input  logic [ppghr_pkg::STAMP_W-1:0]       timestamp,
    input  logic                                cfg_we,
    input  logic [ppghr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppghr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [ppghr_pkg::RATE_W-1:0]        heart_rate
);
    import ppghr_pkg::*;

    // configuration
    logic [CFG_DATA_W-1:0] threshold_reg, min_int_reg, max_int_reg;

    // captured request
    logic                op_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [STAMP_W-1:0]  stamp_reg;

    // algorithm state
    logic [SAMPLE_W-1:0] ring_reg [WINDOW];
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   centre_reg;
    logic [STAMP_W-1:0]  last_reg;
    logic [RATE_W-1:0]   rate_reg;

    // evaluation results
    logic                peak_reg;
    logic [STAMP_W-1:0]  interval_reg;

    // divider
    logic [RATE_W-1:0]   rem_reg;
    logic [RATE_W-1:0]   num_reg;
    logic [RATE_W-1:0]   den_reg;

    logic [RATE_W-1:0]   result_reg;

    logic [SLOT_W:0]     centre_sum;
    logic [SLOT_W-1:0]   slot_inc;
    logic [SLOT_W-1:0]   centre_next;
    logic [SAMPLE_W-1:0] centre_val;
    logic                peak_next;
    logic                warm;
    logic                last_zero;
    logic                ge_min;
    logic                le_max;
    logic                peak_ok;
    logic                need_div;
    logic [RATE_W:0]     trial;
    logic [RATE_W:0]     trial_diff;
    logic                qbit;
    logic [RATE_W-1:0]   rem_next;

    // centre slot and write pointer advance
    always_comb
    begin
        centre_sum = {1'b0, slot_reg} + (SLOT_W + 1)'(WINDOW - HALF_WINDOW);
        if (centre_sum >= (SLOT_W + 1)'(WINDOW))
        begin
            centre_next = SLOT_W'(centre_sum - (SLOT_W + 1)'(WINDOW));
        end
        else
        begin
            centre_next = centre_sum[SLOT_W-1:0];
        end
        if (slot_reg == SLOT_W'(WINDOW - 1))
        begin
            slot_inc = '0;
        end
        else
        begin
            slot_inc = slot_reg + 1'b1;
        end
    end

    // peak test: centre above threshold and no smaller than any ring entry
    always_comb
    begin
        centre_val = ring_reg[centre_reg];
        peak_next  = (centre_val > threshold_reg);
        for (int k = 0; k < WINDOW; k++)
        begin
            if (centre_val < ring_reg[k])
            begin
                peak_next = 1'b0;
            end
        end
    end

    // peak acceptance and rate update decision
    assign warm      = (ring_reg[0] == '0);
    assign last_zero = (last_reg == '0);
    assign ge_min    = (interval_reg >= {{(STAMP_W - CFG_DATA_W){1'b0}}, min_int_reg});
    assign le_max    = (interval_reg <= {{(STAMP_W - CFG_DATA_W){1'b0}}, max_int_reg});
    assign peak_ok   = !warm && peak_reg && (last_zero || ge_min);
    assign need_div  = peak_ok && !last_zero && (interval_reg != '0) && ge_min && le_max;

    assign status.op       = op_reg;
    assign status.need_div = need_div;

    // one restoring division step
    always_comb
    begin
        trial      = {rem_reg, num_reg[RATE_W-1]};
        trial_diff = trial - {1'b0, den_reg};
        qbit       = (trial >= {1'b0, den_reg});
        rem_next   = qbit ? trial_diff[RATE_W-1:0] : trial[RATE_W-1:0];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            min_int_reg   <= MIN_INTERVAL_RESET;
            max_int_reg   <= MAX_INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PEAK_THRESHOLD: threshold_reg <= cfg_data;
                CFG_MIN_INTERVAL:   min_int_reg   <= cfg_data;
                CFG_MAX_INTERVAL:   max_int_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // captured request fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op;
            sample_reg <= ppg_sample;
            stamp_reg  <= timestamp;
        end
    end

    // ring, pointers, last peak and held rate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW; k++)
            begin
                ring_reg[k] <= '0;
            end
            slot_reg   <= '0;
            centre_reg <= '0;
            last_reg   <= '0;
            rate_reg   <= '0;
        end
        else if (cmd.clear)
        begin
            for (int k = 0; k < WINDOW; k++)
            begin
                ring_reg[k] <= '0;
            end
            slot_reg <= '0;
            last_reg <= '0;
            rate_reg <= '0;
        end
        else
        begin
            if (cmd.write_ring)
            begin
                for (int k = 0; k < WINDOW; k++)
                begin
                    if (SLOT_W'(k) == slot_reg)
                    begin
                        ring_reg[k] <= sample_reg;
                    end
                end
                slot_reg   <= slot_inc;
                centre_reg <= centre_next;
            end
            if (cmd.decide && peak_ok)
            begin
                last_reg <= stamp_reg;
            end
            if (cmd.div_step && cmd.div_last)
            begin
                rate_reg <= {num_reg[RATE_W-2:0], qbit};
            end
        end
    end

    // evaluation and divider working registers
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            peak_reg     <= peak_next;
            interval_reg <= stamp_reg - last_reg;
        end
        if (cmd.decide)
        begin
            rem_reg <= '0;
            num_reg <= RATE_NUMERATOR;
            den_reg <= interval_reg[RATE_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[RATE_W-2:0], qbit};
        end
    end

    // output register, zero while slot zero of the ring is empty
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg <= warm ? '0 : rate_reg;
        end
    end

    assign heart_rate = result_reg;

endmodule

// ===== rtl/core/ppg_peak_heart_rate.sv =====
// top level of the optical pulse peak interval heart rate block
//
// samples: sink channel, one request per sensor reading (op, ppg_sample,
//   timestamp); op set clears the ring, last peak time and held rate.
// rates: source channel, exactly one heart_rate result per request, in order.
// cfg_we/cfg_index/cfg_data: register writes (threshold, min and max
//   interval), taken in the cycle cfg_we is high; write only while idle.
// sequence: a clear runs write then finish, a sample write, evaluate,
//   decide and finish; a sample that updates the rate also runs the
//   one-bit-per-cycle divider for 60000 / interval before finish.
// throughput: one request at a time; samples.ready is high only while the
//   controller is idle, so a new request waits until the last one is done.
// the result sits in an output register, so the next request is accepted
//   while it waits; if the receiver still stalls when the next result is
//   ready, the controller holds that result until the register frees.
// reset: rst_n, asynchronous active low, clears the ring, pointers, last peak,
//   held rate and control state, and loads register defaults 20000, 333, 1500.
module ppg_peak_heart_rate (
    input  logic                             clk,
    input  logic                             rst_n,
    ppghr_sample_if.sink                     samples,
    ppghr_rate_if.source                     rates,
    input  logic                             cfg_we,
    input  logic [ppghr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppghr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ppghr_pkg::*;

    ppghr_cmd_t    cmd;
    ppghr_status_t status;

    // controller
    ppghr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples_valid (samples.valid),
        .samples_ready (samples.ready),
        .rates_valid   (rates.valid),
        .rates_ready   (rates.ready),
        .status        (status),
        .cmd           (cmd)
    );

    // datapath
    ppghr_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .op         (samples.op),
        .ppg_sample (samples.ppg_sample),
        .timestamp  (samples.timestamp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .heart_rate (rates.heart_rate)
    );

endmodule

// ===== rtl/core/ppghr_checker.sv =====
// port-level checker for the heart rate block, bound to the top level
module ppghr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          samples_valid,
    input logic                          samples_ready,
    input logic                          rates_valid,
    input logic                          rates_ready,
    input logic [ppghr_pkg::RATE_W-1:0]  heart_rate
);
    import ppghr_pkg::*;

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rates_valid && !rates_ready |=> rates_valid)
    else $error("result dropped while stalled");

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        rates_valid && !rates_ready |=> $stable(heart_rate))
    else $error("result changed while stalled");

    // rate never exceeds the numerator
    assert property (@(posedge clk) disable iff (!rst_n)
        rates_valid |-> heart_rate <= RATE_NUMERATOR)
    else $error("heart rate out of range");

    // one request at a time: ready drops after an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        samples_valid && samples_ready |=> !samples_ready)
    else $error("request accepted while busy");

    // no result can appear in the cycle right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        samples_valid && samples_ready && !rates_valid |=> !rates_valid)
    else $error("result appeared too early");

endmodule

bind ppg_peak_heart_rate ppghr_checker u_ppghr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .samples_valid (samples.valid),
    .samples_ready (samples.ready),
    .rates_valid   (rates.valid),
    .rates_ready   (rates.ready),
    .heart_rate    (rates.heart_rate)
);

// ===== tb/sv/tb_ppg_peak_heart_rate.sv =====
// self-checking testbench for the optical pulse peak interval heart rate block
module tb_ppg_peak_heart_rate;
    import ppghr_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ppghr_sample_if samples_if ();
    ppghr_rate_if   rates_if ();

    ppg_peak_heart_rate u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_if),
        .rates     (rates_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the beat detector state and its registers
    logic [SAMPLE_W-1:0]   win_buf [WINDOW];
    int                    next_slot;
    logic [STAMP_W-1:0]    prev_beat_ms;
    logic [RATE_W-1:0]     held_bpm;
    logic [CFG_DATA_W-1:0] thr_reg;
    logic [CFG_DATA_W-1:0] min_gap_reg;
    logic [CFG_DATA_W-1:0] max_gap_reg;

    // rates still owed by the block, oldest first
    logic [RATE_W-1:0]     pending_rates [$];
    logic [RATE_W-1:0]     want_bpm;

    int                    fail_count;
    int                    long_hold_len;
    int                    phase_items;
    logic                  src_idle_en;
    logic                  sink_idle_en;
    logic [STAMP_W-1:0]    now_ms;

    // clock
    always #5 clk = ~clk;

    // run limit, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("ppg_peak_heart_rate verification failed");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(input logic enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // wipe the ring, last beat time and held rate
    function automatic void clear_beat_state();
        foreach (win_buf[k])
            win_buf[k] = '0;
        next_slot    = 0;
        prev_beat_ms = '0;
        held_bpm     = '0;
    endfunction

    // work out the rate owed for one accepted request
    function automatic void predict_rate(input logic op, input logic [SAMPLE_W-1:0] smp,
                                         input logic [STAMP_W-1:0] stamp);
        int                 slot;
        int                 centre;
        int                 k;
        logic               is_peak;
        logic [STAMP_W-1:0] interval;
        logic [STAMP_W-1:0] quotient;
        if (op == OP_CLEAR)
        begin
            clear_beat_state();
            pending_rates.push_back('0);
            return;
        end
        slot          = next_slot;
        win_buf[slot] = smp;
        next_slot     = (slot + 1) % WINDOW;
        // warm-up: nothing until ring slot zero holds a sample
        if (win_buf[0] == '0)
        begin
            pending_rates.push_back('0);
            return;
        end
        centre  = (slot + WINDOW - HALF_WINDOW) % WINDOW;
        is_peak = (win_buf[centre] > thr_reg);
        for (k = 0; k < WINDOW; k++)
            if (k != centre && win_buf[centre] < win_buf[k])
                is_peak = 1'b0;
        if (is_peak)
        begin
            interval = stamp - prev_beat_ms;
            if (prev_beat_ms == '0 || interval >= min_gap_reg)
            begin
                if (prev_beat_ms != '0 && interval != '0 &&
                    interval >= min_gap_reg && interval <= max_gap_reg)
                begin
                    quotient = {{(STAMP_W-RATE_W){1'b0}}, RATE_NUMERATOR} / interval;
                    held_bpm = quotient[RATE_W-1:0];
                end
                prev_beat_ms = stamp;
            end
        end
        pending_rates.push_back(held_bpm);
    endfunction

    // offer one request and wait for the handshake; valid stays up afterwards
    task automatic send_request(input logic op, input logic [SAMPLE_W-1:0] smp,
                                input logic [STAMP_W-1:0] stamp);
        int gap;
        gap = pick_gap(src_idle_en);
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.op         <= op;
        samples_if.ppg_sample <= smp;
        samples_if.timestamp  <= stamp;
        samples_if.valid      <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (samples_if.ready !== 1'b1);
        predict_rate(op, smp, stamp);
        phase_items++;
    endtask

    // lower valid and wait until every owed rate has come back
    task automatic drain_rates();
        samples_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_rates.size() != 0);
    endtask

    // write all three registers, only while the block is idle
    task automatic set_config(input logic [CFG_DATA_W-1:0] thr, mn, mx);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PEAK_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        thr_reg = thr;
        cfg_index <= CFG_MIN_INTERVAL;
        cfg_data  <= mn;
        @(posedge clk);
        min_gap_reg = mn;
        cfg_index <= CFG_MAX_INTERVAL;
        cfg_data  <= mx;
        @(posedge clk);
        max_gap_reg = mx;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // five samples with a single clear peak in the middle, last one at last_ms
    task automatic send_pulse5(input logic [SAMPLE_W-1:0] peak,
                               input logic [STAMP_W-1:0] last_ms);
        logic [SAMPLE_W-1:0] shape [5];
        int                  i;
        shape = '{16'd1000, 16'd5000, peak, 16'd5000, 16'd1000};
        for (i = 0; i < 5; i++)
            send_request(OP_SAMPLE, shape[i], last_ms - STAMP_W'(40 - 10 * i));
    endtask

    // one triangular beat with a short baseline rest in front
    task automatic send_beat();
        int rest;
        int rise;
        int fall;
        int step_ms;
        int base;
        int top;
        int val;
        int roll;
        int i;
        rest = $urandom_range(0, 3);
        rise = $urandom_range(2, 6);
        fall = $urandom_range(2, 8);
        roll = $urandom_range(0, 19);
        if (roll == 0)
            step_ms = 0;
        else if (roll < 3)
            step_ms = $urandom_range(80, 200);
        else
            step_ms = $urandom_range(4, 60);
        if (thr_reg != 16'hFFFF && $urandom_range(0, 6) != 0)
            top = $urandom_range(int'(thr_reg) + 1, 65535);
        else
            top = $urandom_range(0, 65535);
        base = $urandom_range(1, 8000);
        if (base > top)
            base = top;
        for (i = 1 - rest; i <= rise + fall; i++)
        begin
            now_ms = now_ms + STAMP_W'(step_ms);
            if (i <= 0)
                val = base;
            else if (i <= rise)
                val = base + (top - base) * i / rise;
            else
                val = top - (top - base) * (i - rise) / fall;
            send_request(OP_SAMPLE, SAMPLE_W'(val), now_ms);
        end
    endtask

    // stray sample: full-range value, often a jump or a step back in time
    task automatic send_noise();
        logic [SAMPLE_W-1:0] smp;
        smp = ($urandom_range(0, 9) == 0) ? '0 : SAMPLE_W'($urandom);
        if ($urandom_range(0, 1) == 1)
            now_ms = $urandom;
        else
            now_ms = now_ms + STAMP_W'($urandom_range(0, 3000));
        send_request(OP_SAMPLE, smp, now_ms);
    endtask

    // warm-up while slot zero is empty, and clears with extreme payloads
    task automatic test_warmup_and_clear();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        send_request(OP_SAMPLE, 16'd0, 32'd10);
        send_request(OP_SAMPLE, 16'hFFFF, 32'd20);
        send_request(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_CLEAR, 16'd0, 32'd0);
        drain_rates();
    endtask

    // peak at time zero, wrap of the ms counter, interval at both limits,
    // centre exactly at threshold
    task automatic test_peak_extremes();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_pulse5(16'hFFFF, 32'd0);
        send_pulse5(16'd20001, 32'hFFFF_FF38);
        send_pulse5(16'hFFFF, 32'd133);
        send_pulse5(16'd30000, 32'd1633);
        send_pulse5(THRESHOLD_RESET, 32'd2500);
        drain_rates();
    endtask

    // zero threshold and zero minimum: repeated timestamp keeps the rate
    task automatic test_zero_interval();
        set_config(16'd0, 16'd0, 16'hFFFF);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        send_pulse5(16'd9000, 32'd5000);
        send_pulse5(16'd9000, 32'd5000);
        send_pulse5(16'd9000, 32'd6000);
        drain_rates();
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_output_stall();
        int k;
        set_config(THRESHOLD_RESET, MIN_INTERVAL_RESET, MAX_INTERVAL_RESET);
        src_idle_en   = 1'b0;
        long_hold_len = 300;
        for (k = 0; k < 5; k++)
            send_pulse5(SAMPLE_W'($urandom_range(20001, 65535)), STAMP_W'(10000 + 600 * k));
        drain_rates();
    endtask

    // random pulse trains under several register settings
    task automatic test_random_beats();
        logic [CFG_DATA_W-1:0] cfg_set [8][3];
        int                    p;
        int                    roll;
        cfg_set = '{
            '{THRESHOLD_RESET, MIN_INTERVAL_RESET, MAX_INTERVAL_RESET},
            '{16'd0,     16'd1,     16'hFFFF},
            '{16'hFFFF,  16'd1,     16'd1},
            '{16'd1000,  16'hFFFF,  16'hFFFF},
            '{16'd30000, 16'd200,   16'd2000},
            '{16'd0,     16'd0,     16'd1},
            '{16'd12000, 16'd300,   16'd1500},
            '{16'd40000, 16'd250,   16'd1200}
        };
        for (p = 0; p < 8; p++)
        begin
            set_config(cfg_set[p][0], cfg_set[p][1], cfg_set[p][2]);
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            if (p % 3 == 0)
                now_ms = 32'hFFFF_FFFF - STAMP_W'($urandom_range(0, 20000));
            else
                now_ms = $urandom;
            phase_items = 0;
            while (phase_items < 106)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    send_request(OP_CLEAR, SAMPLE_W'($urandom), $urandom);
                else if (roll < 17)
                    send_noise();
                else
                begin
                    // occasionally change idling so quiet stretches mix with busy ones
                    if ($urandom_range(0, 7) == 0)
                    begin
                        src_idle_en  = ($urandom_range(0, 2) != 0);
                        sink_idle_en = ($urandom_range(0, 2) != 0);
                    end
                    send_beat();
                end
            end
            drain_rates();
        end
    endtask

    // result side: random stalls plus one long hold-off when asked
    initial
    begin : rate_sink
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_len > 0)
            begin
                hold          = long_hold_len;
                long_hold_len = 0;
                rates_if.ready <= 1'b0;
                repeat (hold) @(posedge clk);
                rates_if.ready <= 1'b1;
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                hold = 1 + pick_gap(1'b1);
                rates_if.ready <= 1'b0;
                repeat (hold) @(posedge clk);
                rates_if.ready <= 1'b1;
            end
            else
                rates_if.ready <= 1'b1;
        end
    end

    // compare each returned rate with the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rates_if.valid === 1'b1 && rates_if.ready === 1'b1)
        begin
            if (pending_rates.size() == 0)
            begin
                $display("%0t: unrequested heart_rate, expected none, actual %0d",
                         $time, rates_if.heart_rate);
                fail_count++;
            end
            else
            begin
                want_bpm = pending_rates.pop_front();
                if (rates_if.heart_rate !== want_bpm)
                begin
                    $display("%0t: heart_rate mismatch, expected %0d, actual %0d",
                             $time, want_bpm, rates_if.heart_rate);
                    fail_count++;
                end
            end
        end
    end

    // reset, test sequence and verdict
    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_PEAK_THRESHOLD;
        cfg_data              = '0;
        samples_if.valid      = 1'b0;
        samples_if.op         = OP_SAMPLE;
        samples_if.ppg_sample = '0;
        samples_if.timestamp  = '0;
        rates_if.ready        = 1'b0;
        fail_count            = 0;
        long_hold_len         = 0;
        phase_items           = 0;
        src_idle_en           = 1'b0;
        sink_idle_en          = 1'b0;
        now_ms                = '0;
        clear_beat_state();
        thr_reg     = THRESHOLD_RESET;
        min_gap_reg = MIN_INTERVAL_RESET;
        max_gap_reg = MAX_INTERVAL_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_warmup_and_clear();
        test_peak_extremes();
        test_zero_interval();
        test_output_stall();
        test_random_beats();

        // let any late result show up before the verdict
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("ppg_peak_heart_rate verification clean");
        else
            $display("ppg_peak_heart_rate verification failed");
        $finish;
    end

endmodule
